@@ rtl/core/pltt_pkg.sv @@
// Shared types, widths and codes for the piecewise linear track table.
// No dependencies; every other file in rtl/core but pltt_ram imports this package.
package pltt_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int VAL_W       = 32;          // Q15.16 point values
	localparam int DIFF_W      = 33;          // difference of two values
	localparam int SLOPE_W     = 48;          // signed slope, 2*F fraction bits
	localparam int SLOPE_MAG_W = SLOPE_W - 1; // saturated slope magnitude
	localparam int TERM_W      = 41;          // capped product magnitude
	localparam int NQ          = 5;           // x, y, heading, curvature, width
	localparam int QI_W        = 3;
	localparam int SEG_W       = 10;
	localparam int LIMIT_W     = 31;
	localparam int STATUS_W    = 3;
	localparam int CMD_W       = 2;

	localparam int PT_W        = VAL_W * (NQ + 1); // progress then the values
	localparam int SL_W        = SLOPE_W * NQ;
	localparam int IN_DATA_W   = VAL_W * (NQ + 1);
	localparam int OUT_DATA_W  = ((SEG_W + VAL_W * NQ + 7) / 8) * 8;

	localparam logic [LIMIT_W-1:0] HEADING_LIMIT_RESET = 31'd205887;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NONMONO  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_WIDTH    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_HEADING  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_TOO_FEW  = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIV_GO,
		S_DIV_WAIT,
		S_SLOPE_WR,
		S_SRCH,
		S_SRCH_CMP,
		S_OFFS,
		S_MUL_GO,
		S_MUL_WAIT,
		S_DONE
	} pltt_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

@@ rtl/core/piecewise_linear_track_table_unit.sv @@
// Piecewise linear track table: builds a table of track points and answers queries
// by binary search and linear interpolation. Depends on pltt_pkg, pltt_ram, pltt_div
// and pltt_mul.
//
// One transaction is taken at a time; s_tready is high only while the sequencer is
// idle. Clear and unused commands, and adds or queries refused at once (rejected
// table, full table, too few points), go straight to the final step. An add first
// runs its checks; one that fails them, and an accepted first point, then finish.
// Any later accepted point runs the bit-serial slope divider once per quantity and
// then writes the slope store. A query runs the binary search over the point store
// read port, then the bit-serial multiplier once per quantity. A result that waits
// on m_tready holds the sequencer in its final step. The stores need no clearing
// pass: only entries below the point count are ever used.
module piecewise_linear_track_table_unit #(
	parameter int MAX_POINTS = pltt_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = pltt_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: heading_jump_limit
	input  logic                            cfg_we,
	input  logic [pltt_pkg::LIMIT_W-1:0]    cfg_wdata,
	// slave side
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// position, x_in, y_in, heading_in, curvature_in, width_in (32 bits each)
	input  logic [pltt_pkg::IN_DATA_W-1:0]  s_tdata,
	// command
	input  logic [pltt_pkg::CMD_W-1:0]      s_tuser,
	// master side
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// segment_index (10), x_out, y_out, heading_out, curvature_out, width_out (32
	// each), zero fill
	output logic [pltt_pkg::OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [pltt_pkg::STATUS_W-1:0]   m_tuser
);
	import pltt_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	pltt_state_t state_q, state_d;

	logic [LIMIT_W-1:0]   limit_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 rej_q;

	logic [VAL_W-1:0]     pos_q;
	logic [VAL_W-1:0]     val_q [NQ];
	logic [VAL_W-1:0]     prev_pos_q;
	logic [VAL_W-1:0]     prev_val_q [NQ];
	logic [QI_W-1:0]      qi_q;
	logic [SLOPE_W-1:0]   slope_buf_q [NQ];

	logic [IDX_W-1:0]     lo_q, hi_q, mid_q;
	logic [IDX_W:0]       mid_sum;
	logic [IDX_W-1:0]     mid;
	logic                 srch_more;

	logic [VAL_W-1:0]     base_q [NQ];
	logic [SLOPE_W-1:0]   slope_q [NQ];
	logic [DIFF_W-1:0]    off_q;

	logic [STATUS_W-1:0]  res_status_q;
	logic [SEG_W-1:0]     res_seg_q;
	logic [VAL_W-1:0]     res_val_q [NQ];

	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [STATUS_W-1:0]  m_user_q;
	logic [OUT_DATA_W-1:0] out_word;

	logic                 s_fire;
	logic                 out_free;
	logic [VAL_W-1:0]     in_val [NQ];

	// store ports
	logic                 pt_we, sl_we;
	logic [IDX_W-1:0]     pt_waddr, pt_raddr, sl_waddr;
	logic [PT_W-1:0]      pt_wdata, pt_rd;
	logic [SL_W-1:0]      sl_wdata, sl_rd;
	logic [VAL_W-1:0]     rd_pos;
	logic [VAL_W-1:0]     rd_val [NQ];

	// checks
	logic                 has_prev;
	logic                 fail_mono, fail_width, fail_head, chk_fail;
	logic [STATUS_W-1:0]  chk_status;
	logic [DIFF_W-1:0]    hdiff;
	logic                 last_q;
	logic                 add_refuse, query_refuse;

	// shared units
	logic                 div_start, mul_start;
	unit_stat_t           div_stat, mul_stat;
	logic [DIFF_W-1:0]    div_num_s, div_num_mag, div_den;
	logic                 div_neg;
	logic [SLOPE_MAG_W-1:0] div_quot;
	logic [SLOPE_W-1:0]   div_slope;
	logic [SLOPE_W-1:0]   mul_slope;
	logic [SLOPE_MAG_W-1:0] mul_a;
	logic [DIFF_W-1:0]    mul_b;
	logic                 mul_neg;
	logic [TERM_W-1:0]    mul_mag;
	logic [TERM_W:0]      term;
	logic [TERM_W+1:0]    isum;
	logic [VAL_W-1:0]     isat;

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// unpack the input transaction and the point store word
	always_comb begin
		for (int q = 0; q < NQ; q++) begin
			in_val[q] = s_tdata[VAL_W*(q+1) +: VAL_W];
			rd_val[q] = pt_rd[VAL_W*(q+1) +: VAL_W];
		end
		rd_pos = pt_rd[VAL_W-1:0];
	end

	assign add_refuse   = rej_q || (cnt_q >= CNT_W'(MAX_POINTS));
	assign query_refuse = rej_q || (cnt_q < CNT_W'(2));
	assign last_q       = (qi_q == QI_W'(NQ - 1));

	// point checks, in priority order; all but the width check compare with the previous point
	assign has_prev   = (cnt_q != '0);
	assign fail_mono  = has_prev && ($signed(pos_q) <= $signed(rd_pos));
	assign fail_width = ($signed(val_q[4]) <= $signed(VAL_W'(0)));
	assign hdiff      = {val_q[2][VAL_W-1], val_q[2]} - {rd_val[2][VAL_W-1], rd_val[2]};
	assign fail_head  = has_prev && ($signed(hdiff) > $signed({2'b00, limit_q}));
	assign chk_fail   = fail_mono || fail_width || fail_head;

	always_comb begin
		if (fail_mono) begin
			chk_status = STAT_NONMONO;
		end else if (fail_width) begin
			chk_status = STAT_WIDTH;
		end else if (fail_head) begin
			chk_status = STAT_HEADING;
		end else begin
			chk_status = STAT_OK;
		end
	end

	// binary search midpoint, rounded up
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} + (IDX_W + 1)'(1);
	assign mid       = mid_sum[IDX_W:1];
	assign srch_more = lo_q < hi_q;

	// slope division operands for the quantity in hand
	assign div_num_s   = {val_q[qi_q][VAL_W-1], val_q[qi_q]}
	                   - {prev_val_q[qi_q][VAL_W-1], prev_val_q[qi_q]};
	assign div_neg     = div_num_s[DIFF_W-1];
	assign div_num_mag = div_neg ? -div_num_s : div_num_s;
	assign div_den     = {pos_q[VAL_W-1], pos_q} - {prev_pos_q[VAL_W-1], prev_pos_q};
	assign div_slope   = div_neg ? -{1'b0, div_quot} : {1'b0, div_quot};

	// interpolation operands and the saturating final add
	assign mul_slope = slope_q[qi_q];
	assign mul_neg   = mul_slope[SLOPE_W-1] ^ off_q[DIFF_W-1];
	assign mul_a     = mul_slope[SLOPE_W-1] ? SLOPE_MAG_W'(-mul_slope)
	                                        : mul_slope[SLOPE_MAG_W-1:0];
	assign mul_b     = off_q[DIFF_W-1] ? -off_q : off_q;
	assign term      = mul_neg ? -{1'b0, mul_mag} : {1'b0, mul_mag};
	assign isum      = {{(TERM_W + 2 - VAL_W){base_q[qi_q][VAL_W-1]}}, base_q[qi_q]}
	                 + {term[TERM_W], term};

	always_comb begin
		if ($signed(isum) > $signed((TERM_W + 2)'(32'sh7FFF_FFFF))) begin
			isat = 32'h7FFF_FFFF;
		end else if ($signed(isum) < -$signed((TERM_W + 2)'(33'sh0_8000_0000))) begin
			isat = 32'h8000_0000;
		end else begin
			isat = isum[VAL_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					case (s_tuser)
						CMD_ADD:   state_d = add_refuse ? S_DONE : S_CHECK;
						CMD_QUERY: state_d = query_refuse ? S_DONE : S_SRCH;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_CHECK: begin
				if (chk_fail || !has_prev) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DIV_GO;
				end
			end
			S_DIV_GO:   state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = last_q ? S_SLOPE_WR : S_DIV_GO;
				end
			end
			S_SLOPE_WR: state_d = S_DONE;
			S_SRCH:     state_d = srch_more ? S_SRCH_CMP : S_OFFS;
			S_SRCH_CMP: state_d = S_SRCH;
			S_OFFS:     state_d = S_MUL_GO;
			S_MUL_GO:   state_d = S_MUL_WAIT;
			S_MUL_WAIT: begin
				if (mul_stat.done) begin
					state_d = last_q ? S_DONE : S_MUL_GO;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// store and unit control
	always_comb begin
		pt_we     = 1'b0;
		sl_we     = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		pt_raddr  = lo_q;
		case (state_q)
			S_IDLE:     pt_raddr = IDX_W'(cnt_q - CNT_W'(1)); // previous point
			S_CHECK:    pt_we = !chk_fail;
			S_DIV_GO:   div_start = 1'b1;
			S_SLOPE_WR: sl_we = 1'b1;
			S_SRCH:     pt_raddr = srch_more ? mid : lo_q;
			S_MUL_GO:   mul_start = 1'b1;
			default:    pt_raddr = lo_q;
		endcase
	end

	assign pt_waddr = cnt_q[IDX_W-1:0];
	assign sl_waddr = IDX_W'(cnt_q - CNT_W'(1));

	always_comb begin
		pt_wdata[VAL_W-1:0] = pos_q;
		for (int q = 0; q < NQ; q++) begin
			pt_wdata[VAL_W*(q+1) +: VAL_W]  = val_q[q];
			sl_wdata[SLOPE_W*q +: SLOPE_W] = slope_buf_q[q];
		end
	end

	// pack the result transaction: segment, five values, zero fill
	always_comb begin
		out_word = '0;
		out_word[SEG_W-1:0] = res_seg_q;
		for (int q = 0; q < NQ; q++) begin
			out_word[SEG_W + VAL_W*q +: VAL_W] = res_val_q[q];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			limit_q    <= HEADING_LIMIT_RESET;
			cnt_q      <= '0;
			rej_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			qi_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			// table state: clear, refusal of a full table, failed checks, growth
			if (s_fire && s_tuser == CMD_CLEAR) begin
				cnt_q <= '0;
				rej_q <= 1'b0;
			end else if (s_fire && s_tuser == CMD_ADD && !rej_q
			             && cnt_q >= CNT_W'(MAX_POINTS)) begin
				rej_q <= 1'b1;
			end
			if (state_q == S_CHECK) begin
				if (chk_fail) begin
					rej_q <= 1'b1;
				end else if (!has_prev) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == S_SLOPE_WR) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// quantity counter for the shared units
			if (state_q == S_CHECK || state_q == S_OFFS) begin
				qi_q <= '0;
			end else if ((state_q == S_DIV_WAIT && div_stat.done)
			             || (state_q == S_MUL_WAIT && mul_stat.done)) begin
				qi_q <= qi_q + 1'b1;
			end
			// output register: load when free, drop once taken
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			pos_q     <= s_tdata[VAL_W-1:0];
			res_seg_q <= '0;
			for (int q = 0; q < NQ; q++) begin
				val_q[q]     <= in_val[q];
				res_val_q[q] <= '0;
			end
			case (s_tuser)
				CMD_ADD: begin
					if (rej_q) begin
						res_status_q <= STAT_REJECTED;
					end else if (cnt_q >= CNT_W'(MAX_POINTS)) begin
						res_status_q <= STAT_FULL;
					end else begin
						res_status_q <= STAT_OK;
					end
				end
				CMD_QUERY: begin
					if (rej_q) begin
						res_status_q <= STAT_REJECTED;
					end else if (cnt_q < CNT_W'(2)) begin
						res_status_q <= STAT_TOO_FEW;
					end else begin
						res_status_q <= STAT_OK;
					end
					lo_q <= '0;
					hi_q <= IDX_W'(cnt_q - CNT_W'(2));
				end
				default: res_status_q <= STAT_OK;
			endcase
		end
		if (state_q == S_CHECK) begin
			res_status_q <= chk_status;
			prev_pos_q   <= rd_pos;
			for (int q = 0; q < NQ; q++) begin
				prev_val_q[q] <= rd_val[q];
			end
			if (!chk_fail) begin
				res_seg_q <= SEG_W'(cnt_q);
			end
		end
		if (state_q == S_DIV_WAIT && div_stat.done) begin
			slope_buf_q[qi_q] <= div_slope;
		end
		if (state_q == S_SRCH && srch_more) begin
			mid_q <= mid;
		end
		if (state_q == S_SRCH_CMP) begin
			if ($signed(rd_pos) <= $signed(pos_q)) begin
				lo_q <= mid_q;
			end else begin
				hi_q <= mid_q - 1'b1;
			end
		end
		if (state_q == S_OFFS) begin
			off_q     <= {pos_q[VAL_W-1], pos_q} - {rd_pos[VAL_W-1], rd_pos};
			res_seg_q <= SEG_W'(lo_q);
			for (int q = 0; q < NQ; q++) begin
				base_q[q]  <= rd_val[q];
				slope_q[q] <= sl_rd[SLOPE_W*q +: SLOPE_W];
			end
		end
		if (state_q == S_MUL_WAIT && mul_stat.done) begin
			res_val_q[qi_q] <= isat;
		end
		if (state_q == S_DONE && out_free) begin
			m_user_q <= res_status_q;
			m_data_q <= out_word;
		end
	end

	pltt_ram #(
		.WIDTH (PT_W),
		.DEPTH (MAX_POINTS)
	) u_point_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rd)
	);

	pltt_ram #(
		.WIDTH (SL_W),
		.DEPTH (MAX_POINTS)
	) u_slope_ram (
		.clk   (clk),
		.we    (sl_we),
		.waddr (sl_waddr),
		.wdata (sl_wdata),
		.raddr (lo_q),
		.rdata (sl_rd)
	);

	pltt_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_mag),
		.den    (div_den),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	pltt_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.mag    (mul_mag),
		.stat   (mul_stat)
	);

	// the point count never passes the table depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond table depth");

	// the shared units are quiet whenever the sequencer is idle
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_stat.busy && !mul_stat.busy)
		else $error("arithmetic unit busy while idle");

	// a clear transaction empties the table on the next edge
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tuser == CMD_CLEAR |=> cnt_q == '0 && !rej_q)
		else $error("clear did not empty the table");
endmodule

@@ rtl/core/pltt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the point and slope stores.
module pltt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/pltt_div.sv @@
// Bit-serial restoring divider: floor(num * 2^(2F) / den), saturated.
// Depends on pltt_pkg; one quotient bit per clock.
module pltt_div #(
	parameter int FRAC_BITS = pltt_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pltt_pkg::DIFF_W-1:0]     num,
	input  logic [pltt_pkg::DIFF_W-1:0]     den,
	output logic [pltt_pkg::SLOPE_MAG_W-1:0] quot,
	output pltt_pkg::unit_stat_t            stat
);
	import pltt_pkg::*;

	localparam int DVD_W = DIFF_W + 2 * FRAC_BITS;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]       dvd_q;
	logic [DIFF_W-1:0]      den_q;
	logic [DIFF_W-1:0]      rem_q;
	logic [SLOPE_MAG_W-1:0] quot_q;
	logic                   ovf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DIFF_W-1:0]      trial;
	logic                   ge;

	// remainder stays below den <= 2^32, so its top bit is always clear
	assign trial = {rem_q[DIFF_W-2:0], dvd_q[DVD_W-1]};
	assign ge    = trial >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {num, {(2 * FRAC_BITS){1'b0}}};
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q  <= ge ? trial - den_q : trial;
			ovf_q  <= ovf_q | quot_q[SLOPE_MAG_W-1];
			quot_q <= {quot_q[SLOPE_MAG_W-2:0], ge};
		end
	end

	assign quot      = ovf_q ? '1 : quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

@@ rtl/core/pltt_mul.sv @@
// Shift-add multiplier for |slope| * |offset|, scaled down by 2^(2F) and capped.
// Depends on pltt_pkg; one multiplier bit per clock.
module pltt_mul #(
	parameter int FRAC_BITS = pltt_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [pltt_pkg::SLOPE_MAG_W-1:0] a,
	input  logic [pltt_pkg::DIFF_W-1:0]      b,
	output logic [pltt_pkg::TERM_W-1:0]      mag,
	output pltt_pkg::unit_stat_t             stat
);
	import pltt_pkg::*;

	localparam int PROD_W = SLOPE_MAG_W + DIFF_W;
	localparam int CNT_W  = $clog2(DIFF_W + 1);
	localparam logic [PROD_W-1:0] CAP = PROD_W'(1) << (TERM_W - 1);

	logic [SLOPE_MAG_W-1:0] a_q;
	logic [SLOPE_MAG_W-1:0] p_q;
	logic [DIFF_W-1:0]      b_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [SLOPE_MAG_W:0]   sum;
	logic [PROD_W-1:0]      prod_sh;

	assign sum = {1'b0, p_q} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIFF_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= sum[SLOPE_MAG_W:1];
			b_q <= {sum[0], b_q[DIFF_W-1:1]};
		end
	end

	assign prod_sh   = {p_q, b_q} >> (2 * FRAC_BITS);
	assign mag       = (prod_sh > CAP) ? CAP[TERM_W-1:0] : prod_sh[TERM_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

@@ bench/tb_piecewise_linear_track_table_unit.sv @@
// Self-checking bench for piecewise_linear_track_table_unit: builds and queries track
// tables through the stream ports and compares every result with an in-bench predictor.
// Depends on pltt_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_piecewise_linear_track_table_unit;
	import pltt_pkg::*;

	localparam int N_PTS    = 1024;
	localparam int F2       = 2 * FRAC_BITS_DEF;
	localparam longint SLOPE_CAP = (64'sd1 <<< 47) - 1;
	localparam longint TERM_CAP  = 64'sd1 <<< 40;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused command code

	// one input transaction
	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [31:0]      pos;
		logic [31:0]      val [NQ];
	} track_cmd_t;

	// one result transaction
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SEG_W-1:0]    seg;
		logic [31:0]         val [NQ];
	} track_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	piecewise_linear_track_table_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// predictor state: a private copy of the table
	longint      jump_limit;
	int          n_points;
	bit          rejected;
	longint      prog_tab [N_PTS];
	longint      val_tab  [NQ][N_PTS];
	longint      slope_tab[NQ][N_PTS];

	track_cmd_t  pending_cmds[$];
	track_res_t  expected_results[$];
	int          mismatches = 0;
	int          n_results = 0;
	int          n_ok_queries = 0;
	bit          calm = 1'b0;   // no idling while set
	bit          feed_on = 1'b0;

	// exact quotient num * 2^2F / den, truncated toward zero, magnitude capped
	function automatic longint slope_of(longint num, longint den);
		logic [127:0] n, q;
		n = (num < 0 ? -num : num);
		n = n << F2;
		q = n / den;
		if (q > SLOPE_CAP) q = SLOPE_CAP;
		return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic logic [31:0] interp(longint base, longint slope, longint off);
		logic [127:0] a, b, p;
		longint term, sum;
		bit neg;
		neg = (slope < 0) != (off < 0);
		a = slope < 0 ? -slope : slope;
		b = off < 0 ? -off : off;
		p = (a * b) >> F2;
		if (p > TERM_CAP) p = TERM_CAP;
		term = neg ? -longint'(p[63:0]) : longint'(p[63:0]);
		sum = base + term;
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		return sum[31:0];
	endfunction

	function automatic track_res_t table_step(track_cmd_t c);
		track_res_t r;
		longint pos, v[NQ], off;
		int lo, hi, mid;
		r.status = STAT_OK;
		r.seg = '0;
		foreach (r.val[q]) r.val[q] = '0;
		pos = longint'(signed'(c.pos));
		foreach (v[q]) v[q] = longint'(signed'(c.val[q]));
		if (c.cmd == CMD_CLEAR) begin
			n_points = 0;
			rejected = 1'b0;
		end else if (c.cmd == CMD_ADD) begin
			if (rejected) r.status = STAT_REJECTED;
			else if (n_points >= N_PTS) r.status = STAT_FULL;
			else if (n_points > 0 && pos <= prog_tab[n_points-1]) r.status = STAT_NONMONO;
			else if (v[4] <= 0) r.status = STAT_WIDTH;
			else if (n_points > 0 && v[2] - val_tab[2][n_points-1] > jump_limit)
				r.status = STAT_HEADING;
			if (r.status == STAT_OK) begin
				prog_tab[n_points] = pos;
				for (int q = 0; q < NQ; q++) begin
					val_tab[q][n_points] = v[q];
					if (n_points > 0)
						slope_tab[q][n_points-1] = slope_of(v[q] - val_tab[q][n_points-1],
							pos - prog_tab[n_points-1]);
				end
				r.seg = n_points[SEG_W-1:0];
				n_points++;
			end else if (r.status != STAT_REJECTED) begin
				rejected = 1'b1;
			end
		end else if (c.cmd == CMD_QUERY) begin
			if (rejected) r.status = STAT_REJECTED;
			else if (n_points < 2) r.status = STAT_TOO_FEW;
			else begin
				lo = 0;
				hi = n_points - 2;
				while (lo < hi) begin
					mid = (lo + hi + 1) / 2;
					if (prog_tab[mid] <= pos) lo = mid; else hi = mid - 1;
				end
				off = pos - prog_tab[lo];
				r.seg = lo[SEG_W-1:0];
				for (int q = 0; q < NQ; q++)
					r.val[q] = interp(val_tab[q][lo], slope_tab[q][lo], off);
			end
		end
		return r;
	endfunction

	// driver: present pending commands, predict at acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				track_cmd_t c;
				c = pending_cmds.pop_front();
				expected_results.push_back(table_step(c));
			end
			if (!(s_tvalid && !s_tready)) begin
				if (feed_on && pending_cmds.size() > (s_tvalid && s_tready ? 0 : 0)
						&& (calm || $urandom_range(99) >= 38)) begin
					// the head may just have been popped above
					if (pending_cmds.size() > 0) begin
						s_tvalid <= 1'b1;
						s_tuser  <= pending_cmds[0].cmd;
						s_tdata  <= {pending_cmds[0].val[4], pending_cmds[0].val[3],
							pending_cmds[0].val[2], pending_cmds[0].val[1],
							pending_cmds[0].val[0], pending_cmds[0].pos};
					end else
						s_tvalid <= 1'b0;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: random back-pressure, compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				track_res_t e;
				logic [SEG_W-1:0] got_seg;
				bit bad;
				got_seg = m_tdata[SEG_W-1:0];
				n_results++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d seg %0d", m_tuser, got_seg);
				end else begin
					e = expected_results.pop_front();
					bad = (m_tuser != e.status) || (got_seg != e.seg)
						|| (m_tdata[OUT_DATA_W-1:SEG_W + VAL_W*NQ] != '0);
					for (int q = 0; q < NQ; q++)
						if (m_tdata[SEG_W + VAL_W*q +: VAL_W] != e.val[q]) bad = 1'b1;
					if (e.status == STAT_OK && m_tuser == STAT_OK && e.val[4] != 0)
						n_ok_queries++;
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: status exp %0d got %0d, seg exp %0d got %0d",
								e.status, m_tuser, e.seg, got_seg);
							for (int q = 0; q < NQ; q++)
								$display("  field %0d exp %h got %h", q, e.val[q],
									m_tdata[SEG_W + VAL_W*q +: VAL_W]);
						end
					end
				end
			end
			m_tready <= calm || ($urandom_range(99) >= 38);
		end
	end

	function automatic track_cmd_t mk(logic [CMD_W-1:0] cmd, logic [31:0] pos,
			logic [31:0] x, logic [31:0] y, logic [31:0] h, logic [31:0] k, logic [31:0] w);
		track_cmd_t c;
		c.cmd = cmd;
		c.pos = pos;
		c.val[0] = x; c.val[1] = y; c.val[2] = h; c.val[3] = k; c.val[4] = w;
		return c;
	endfunction

	function automatic logic [31:0] rnd32();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	// a well-formed track: rising progress, positive width, bounded heading rise
	task automatic queue_track(int npts, int nq);
		longint p, h;
		p = longint'($urandom_range(0, 32'h0010_0000)) - 64'sd524288;
		h = longint'($urandom_range(0, 32'h0002_0000)) - 64'sd65536;
		pending_cmds.push_back(mk(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom));
		for (int i = 0; i < npts; i++) begin
			pending_cmds.push_back(mk(CMD_ADD, p[31:0], rnd32(), rnd32(), h[31:0], rnd32(),
				$urandom_range(1, 32'h7FFF_FFFF)));
			p += ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 32'h0008_0000);
			h += longint'($urandom_range(0, 200000)) - 64'sd90000;
		end
		for (int i = 0; i < nq; i++)
			pending_cmds.push_back(mk(($urandom_range(9) == 0) ? CMD_ADD : CMD_QUERY,
				($urandom_range(3) == 0) ? $urandom : p[31:0] - $urandom_range(0, 32'h0020_0000),
				rnd32(), rnd32(), rnd32(), rnd32(), rnd32()));
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		jump_limit = longint'(v);
	endtask

	initial begin
		jump_limit = longint'(HEADING_LIMIT_RESET);
		n_points = 0;
		rejected = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: refusals, extremes, every failure in check order
		pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_SPARE, '1, '1, '1, '1, '1, '1));
		pending_cmds.push_back(mk(CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			0, 32'h8000_0000, 1));
		pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd205887, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pending_cmds.push_back(mk(CMD_QUERY, 32'h8000_0000, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_QUERY, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_ADD, 32'h7FFF_FFFF, 0, 0, 0, 0, 5));   // not rising
		pending_cmds.push_back(mk(CMD_ADD, 0, 0, 0, 0, 0, 5));               // rejected
		pending_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_ADD, 0, 0, 0, 0, 0, 0));               // zero width
		pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_ADD, 0, 0, 0, 0, 0, 32'h8000_0000));   // negative width
		pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_ADD, 0, 0, 0, 0, 0, 1));
		pending_cmds.push_back(mk(CMD_ADD, 1, 1, 1, 32'd205888, 1, 1));      // heading jump
		pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_ADD, 0, 0, 0, 32'h7FFF_FFFF, 0, 1));
		pending_cmds.push_back(mk(CMD_ADD, 1, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 1)); // fall
		pending_cmds.push_back(mk(CMD_QUERY, 32'h0001_0000, 0, 0, 0, 0, 0));
		feed_on = 1'b1;
		wait_drained();

		// random phases under several jump limits, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			feed_on = 1'b0;
			case (ph)
				0: write_limit('0);
				1: write_limit('1);
				2: write_limit(31'd205887);
				default: write_limit(LIMIT_W'($urandom_range(0, 300000)));
			endcase
			calm = (ph == 4);
			for (int t = 0; t < 5; t++) begin
				if ($urandom_range(4) == 0) begin
					for (int i = 0; i < 6; i++)
						pending_cmds.push_back(mk(CMD_W'($urandom), rnd32(), rnd32(), rnd32(),
							rnd32(), rnd32(), rnd32()));
				end
				queue_track($urandom_range(0, 6), $urandom_range(2, 5));
			end
			feed_on = 1'b1;
			wait_drained();
		end

		$display("Covered %0d results, %0d successful queries, jump limit swept 0 to max,",
			n_results, n_ok_queries);
		$display("with every check failure and refusal of a small table; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
